/* rtl/ecmac_pkg.sv */
// Shared types and fixed constants of the conductivity meter with autoranging and calibration.
package ecmac_pkg;

  // Field widths of the transactions
  localparam int unsigned V_W   = 17;
  localparam int unsigned T_W   = 11;
  localparam int unsigned EC_W  = 24;
  localparam int unsigned ST_W  = 3;
  localparam int unsigned K_W   = 16;

  // Internal widths that do not depend on the shunt or gain parameters
  localparam int unsigned TF_W  = 17;           // 17200 + 37*t stays below 2^17
  localparam int unsigned VK_W  = V_W + K_W;    // voltage times cell constant
  localparam int unsigned DIV_QW = EC_W + 1;    // quotient bits, top bit flags overflow

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_K_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_K_HIGH   = 2'd2;

  localparam logic [K_W-1:0] K_RESET = 16'd16384;   // 1.0 in Q2.14

  // Temperature factor times 32000 is TF_BASE + TF_SLOPE * t
  localparam int unsigned TF_BASE  = 17200;
  localparam int unsigned TF_SLOPE = 37;

  // Buffer recognition: 10000*v against shunt*gain times these factors
  localparam int unsigned V_SCALE_CAL = 10000;
  localparam int unsigned BUF_LO_MIN  = 144;
  localparam int unsigned BUF_LO_MAX  = 304;
  localparam int unsigned BUF_HI_MIN  = 1440;
  localparam int unsigned BUF_HI_MAX  = 2688;

  // Range hysteresis: v*k*25 against SG<<14 and v*k*125 against SG<<16
  localparam int unsigned HYS_HI_MUL   = 25;
  localparam int unsigned HYS_LO_MUL   = 125;
  localparam int unsigned HYS_HI_SHIFT = 14;
  localparam int unsigned HYS_LO_SHIFT = 16;

  // Measurement quotient v*k*EC_SCALE / (SG*tf)
  localparam int unsigned EC_SCALE   = 8000000;
  localparam int unsigned EC_SCALE_W = 23;

  // Cell constant quotient SG*buffer*K_NUM_SCALE*tf / (K_DEN_SCALE*v)
  localparam int unsigned BUF_LOW_VAL   = 1413;
  localparam int unsigned BUF_HIGH_VAL  = 12880;
  localparam int unsigned K_NUM_SCALE   = 128;
  localparam int unsigned K_NUM_EXTRA_W = 21;   // 12880*128 stays below 2^21
  localparam int unsigned K_DEN_SCALE   = 15625000;
  localparam int unsigned K_DEN_SCALE_W = 24;
  localparam int unsigned K_MIN_SHIFT   = 13;   // 0.5 in Q2.14
  localparam int unsigned K_MAX_MUL     = 24576; // 1.5 in Q2.14
  localparam int unsigned K_MAX_MUL_W   = 15;

  typedef enum logic [ST_W-1:0] {
    ST_MEASURED    = 3'd0,
    ST_LOW_STORED  = 3'd1,
    ST_HIGH_STORED = 3'd2,
    ST_NO_BUFFER   = 3'd3,
    ST_K_RANGE     = 3'd4,
    ST_ADC_FAILED  = 3'd5
  } status_t;

  typedef struct packed {
    logic [V_W-1:0] probe_voltage;
    logic [T_W-1:0] temp_sixteenths;
    logic           adc_failed;
  } in_item_t;

  typedef struct packed {
    logic [EC_W-1:0] ec_value;
    status_t         status;
    logic [K_W-1:0]  k_value;
  } out_item_t;

  typedef struct packed {
    logic              done;
    logic [DIV_QW-1:0] quo;
  } div_res_t;

endpackage

/* rtl/ecmac_div.sv */
// Iterative restoring divider with one compare-and-subtract step per cycle.
module ecmac_div
  import ecmac_pkg::*;
#(
  parameter int unsigned DIV_W = 66,
  parameter int unsigned DEN_W = 42
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output div_res_t         res
);

  localparam int unsigned CNT_W = $clog2(DIV_QW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_QW - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  ds_r, ds_nxt;
  logic [DIV_QW-1:0] quo_r, quo_nxt;
  logic              ge;

  assign ge = (rem_r >= ds_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    ds_nxt   = ds_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = num;
      // The first step weighs the divisor by 2^(DIV_QW-1).
      ds_nxt   = DIV_W'(den) << (DIV_QW - 1);
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_QW-2:0], ge};
      if (ge) begin
        rem_nxt = rem_r - ds_r;
      end
      ds_nxt  = ds_r >> 1;
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    ds_r  <= ds_nxt;
    quo_r <= quo_nxt;
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;

endmodule

/* rtl/ec_meter_autorange_calibration.sv */
// Top level of the conductivity meter: sequencer, cell constant storage and output register.
//
//   Channel  Ports                              Transfer
//   -------  ---------------------------------  ------------------------------------------
//   input    in_valid, in_ready, in_data        one sample, taken when valid and ready
//   result   out_valid, out_ready, out_data     one result per sample, held until taken
//   config   cfg_we, cfg_index, cfg_wdata       one register write per cycle with cfg_we
//
// A sample with the converter failure flag set goes from idle straight to the emit state,
// and a calibration sample outside both buffer windows passes the prepare and check states first.
// A measurement and a calibration with a recognized buffer both pass through the
// shared 25-step divider that forms both the compensated conductivity and the cell constant.
// in_ready is high only while the sequencer is idle and rises with the result; a finished
// result waits in the output register, and the next sample can be taken while it waits.
// A stalled receiver holds the sequencer in its last state until the output register is free.
// Reset is synchronous and active low; it loads 1.0 into all three cell constants.
module ec_meter_autorange_calibration
  import ecmac_pkg::*;
#(
  parameter int unsigned SHUNT_RES = 820,
  parameter int unsigned GAIN_REF  = 200
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Shunt resistance times reference gain sets every threshold and both quotients.
  localparam longint unsigned SG = longint'(SHUNT_RES) * longint'(GAIN_REF);
  localparam int unsigned SG_W = $clog2(SG + 1);

  // Buffer recognition compares 10000*v against SG times a factor below 2^12.
  localparam int unsigned CAL_W = (SG_W + 12 > 31) ? SG_W + 12 : 31;
  localparam logic [CAL_W-1:0] CAL_LO_MIN = CAL_W'(SG * BUF_LO_MIN);
  localparam logic [CAL_W-1:0] CAL_LO_MAX = CAL_W'(SG * BUF_LO_MAX);
  localparam logic [CAL_W-1:0] CAL_HI_MIN = CAL_W'(SG * BUF_HI_MIN);
  localparam logic [CAL_W-1:0] CAL_HI_MAX = CAL_W'(SG * BUF_HI_MAX);

  // Hysteresis compares v*k*125 (below 2^40) against SG<<16.
  localparam int unsigned HYS_W = (SG_W + HYS_LO_SHIFT > 40) ? SG_W + HYS_LO_SHIFT : 40;
  localparam logic [HYS_W-1:0] HYS_HI_REF = HYS_W'(SG << HYS_HI_SHIFT);
  localparam logic [HYS_W-1:0] HYS_LO_REF = HYS_W'(SG << HYS_LO_SHIFT);

  // Numerator and denominator widths of the two quotients.
  localparam int unsigned KNC_W = SG_W + K_NUM_EXTRA_W;
  localparam int unsigned NE_W  = VK_W + EC_SCALE_W;
  localparam int unsigned NK_W  = KNC_W + TF_W;
  localparam int unsigned DE_W  = SG_W + TF_W;
  localparam int unsigned DK_W  = V_W + K_DEN_SCALE_W;
  localparam int unsigned N_W   = (NE_W > NK_W) ? NE_W : NK_W;
  localparam int unsigned D_W   = (DE_W > DK_W) ? DE_W : DK_W;
  localparam int unsigned DIV_W = (N_W + 2 > D_W + DIV_QW) ? N_W + 2 : D_W + DIV_QW;
  localparam int unsigned KC_W  = (N_W > D_W + K_MAX_MUL_W) ? N_W : D_W + K_MAX_MUL_W;

  localparam logic [KNC_W-1:0] KNUM_LOW  = KNC_W'(SG * BUF_LOW_VAL * K_NUM_SCALE);
  localparam logic [KNC_W-1:0] KNUM_HIGH = KNC_W'(SG * BUF_HIGH_VAL * K_NUM_SCALE);
  localparam logic [SG_W-1:0]  SG_C      = SG_W'(SG);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_HYST, S_MUL, S_MPROD, S_CAL, S_KPROD,
    S_KLO, S_KHI, S_DSTART, S_DWAIT, S_EMIT
  } state_t;

  state_t           state_r;
  logic             cal_mode_r;
  logic [K_W-1:0]   k_low_store_r;
  logic [K_W-1:0]   k_high_store_r;
  logic [K_W-1:0]   k_active_r;

  // Working registers of the current transaction
  logic [V_W-1:0]   v_r;
  logic [T_W-1:0]   t_r;
  logic [TF_W-1:0]  tf_r;
  logic [VK_W-1:0]  vk_r;
  logic [CAL_W-1:0] v10k_r;
  logic             is_low_r;
  logic             k_lo_ok_r;
  logic             k_hi_ok_r;
  logic [N_W-1:0]   n_r;
  logic [D_W-1:0]   d_r;
  out_item_t        res_r;

  logic             out_valid_r;
  out_item_t        out_data_r;

  logic [HYS_W-1:0] vk_hi;
  logic [HYS_W-1:0] vk_lo;
  logic             cal_low_hit;
  logic             cal_high_hit;
  logic [DIV_W-1:0] div_num;
  logic [D_W:0]     div_den;
  logic             div_start;
  div_res_t         div_res;
  logic             emit_go;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The output register is loaded when it is empty or being emptied in this cycle.
  assign emit_go = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  assign vk_hi = HYS_W'(vk_r) * HYS_W'(HYS_HI_MUL);
  assign vk_lo = HYS_W'(vk_r) * HYS_W'(HYS_LO_MUL);

  assign cal_low_hit  = (v10k_r > CAL_LO_MIN) && (v10k_r < CAL_LO_MAX);
  assign cal_high_hit = (v10k_r > CAL_HI_MIN) && (v10k_r < CAL_HI_MAX);

  // Both quotients are even-denominator round-half-up divisions, so they are formed
  // as floor((2N + D) / 2D) on the reduced numerator and denominator.
  assign div_num   = (DIV_W'(n_r) << 1) + DIV_W'(d_r);
  assign div_den   = {d_r, 1'b0};
  assign div_start = (state_r == S_DSTART);

  ecmac_div #(
    .DIV_W (DIV_W),
    .DEN_W (D_W + 1)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .res   (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      cal_mode_r     <= 1'b0;
      k_low_store_r  <= K_RESET;
      k_high_store_r <= K_RESET;
      k_active_r     <= K_RESET;
      out_valid_r    <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !emit_go) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            v_r <= in_data.probe_voltage;
            t_r <= in_data.temp_sixteenths;
            if (in_data.adc_failed) begin
              // A failed conversion is reported at once and changes no state.
              res_r.ec_value <= '0;
              res_r.status   <= ST_ADC_FAILED;
              res_r.k_value  <= k_active_r;
              state_r        <= S_EMIT;
            end else begin
              state_r <= S_PREP;
            end
          end
        end

        S_PREP: begin
          tf_r    <= TF_W'(TF_BASE) + TF_W'(t_r) * TF_W'(TF_SLOPE);
          vk_r    <= VK_W'(v_r) * VK_W'(k_active_r);
          v10k_r  <= CAL_W'(v_r) * CAL_W'(V_SCALE_CAL);
          state_r <= cal_mode_r ? S_CAL : S_HYST;
        end

        S_HYST: begin
          // Switch to the high constant above 2.5 and back below 2.0; keep it in between.
          if (vk_hi > HYS_HI_REF) begin
            k_active_r <= k_high_store_r;
          end else if (vk_lo < HYS_LO_REF) begin
            k_active_r <= k_low_store_r;
          end
          state_r <= S_MUL;
        end

        S_MUL: begin
          vk_r    <= VK_W'(v_r) * VK_W'(k_active_r);
          state_r <= S_MPROD;
        end

        S_MPROD: begin
          n_r     <= N_W'(vk_r) * N_W'(EC_SCALE);
          d_r     <= D_W'(SG_C) * D_W'(tf_r);
          state_r <= S_DSTART;
        end

        S_CAL: begin
          if (cal_low_hit) begin
            is_low_r <= 1'b1;
            state_r  <= S_KPROD;
          end else if (cal_high_hit) begin
            is_low_r <= 1'b0;
            state_r  <= S_KPROD;
          end else begin
            res_r.ec_value <= '0;
            res_r.status   <= ST_NO_BUFFER;
            res_r.k_value  <= k_active_r;
            state_r        <= S_EMIT;
          end
        end

        S_KPROD: begin
          n_r     <= N_W'(is_low_r ? KNUM_LOW : KNUM_HIGH) * N_W'(tf_r);
          d_r     <= D_W'(v_r) * D_W'(K_DEN_SCALE);
          state_r <= S_KLO;
        end

        S_KLO: begin
          k_lo_ok_r <= KC_W'(n_r) > (KC_W'(d_r) << K_MIN_SHIFT);
          state_r   <= S_KHI;
        end

        S_KHI: begin
          k_hi_ok_r <= KC_W'(n_r) < KC_W'(d_r) * KC_W'(K_MAX_MUL);
          state_r   <= S_DSTART;
        end

        S_DSTART: begin
          state_r <= S_DWAIT;
        end

        S_DWAIT: begin
          if (div_res.done) begin
            if (!cal_mode_r) begin
              // The quotient's top bit means the value does not fit in Q8.16.
              res_r.ec_value <= div_res.quo[DIV_QW-1] ? '1 : div_res.quo[EC_W-1:0];
              res_r.status   <= ST_MEASURED;
              res_r.k_value  <= k_active_r;
            end else if (k_lo_ok_r && k_hi_ok_r) begin
              res_r.ec_value <= '0;
              res_r.k_value  <= div_res.quo[K_W-1:0];
              if (is_low_r) begin
                k_low_store_r <= div_res.quo[K_W-1:0];
                res_r.status  <= ST_LOW_STORED;
              end else begin
                k_high_store_r <= div_res.quo[K_W-1:0];
                res_r.status   <= ST_HIGH_STORED;
              end
            end else begin
              res_r.ec_value <= '0;
              res_r.status   <= ST_K_RANGE;
              res_r.k_value  <= (|div_res.quo[DIV_QW-1:K_W]) ? '1 : div_res.quo[K_W-1:0];
            end
            state_r <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (emit_go) begin
            out_data_r  <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase

      // Writes are to arrive only while idle, so they never race the sequencer; the block does not enforce this.
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CAL_MODE: begin
            cal_mode_r <= cfg_wdata[0];
          end
          CFG_K_LOW: begin
            k_low_store_r <= cfg_wdata[K_W-1:0];
            k_active_r    <= cfg_wdata[K_W-1:0];
          end
          CFG_K_HIGH: begin
            k_high_store_r <= cfg_wdata[K_W-1:0];
          end
          default: begin
            cal_mode_r <= cal_mode_r;
          end
        endcase
      end
    end
  end

endmodule
